// ----- src/msps_pkg.sv -----
// Shared constants, word layout and types for the multipath send path selector.
package msps_pkg;

  // Default number of path records examined per scan
  localparam int DEFAULT_MAX_PATHS = 8;

  // Configuration register reset
  localparam int          LIMIT_W     = 8;
  localparam logic [7:0]  LIMIT_RESET = 8'd3;

  // Field widths
  localparam int TIME_W  = 64;
  localparam int BYTES_W = 64;
  localparam int REP_W   = 8;

  // Input tdata layout, lowest bit first
  localparam int OFS_ACTIVE   = 0;
  localparam int OFS_VERIFIED = 1;
  localparam int OFS_CH_TIME  = 2;
  localparam int OFS_RTX      = OFS_CH_TIME + TIME_W;
  localparam int OFS_NOW      = OFS_RTX + TIME_W;
  localparam int OFS_REPEATS  = OFS_NOW + TIME_W;
  localparam int OFS_RESP     = OFS_REPEATS + REP_W;
  localparam int OFS_CWND     = OFS_RESP + 1;
  localparam int OFS_BIF      = OFS_CWND + BYTES_W;
  localparam int OFS_ACTION   = OFS_BIF + BYTES_W;
  localparam int OFS_STREAM   = OFS_ACTION + 1;
  localparam int IN_BITS      = OFS_STREAM + 1;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout
  localparam int OUT_CHOSEN_W = 3;
  localparam int OUT_DATA_W   = 8;

  // What one record does to the running pick
  typedef struct packed {
    logic take;        // record becomes the pick
    logic take_valid;  // pick came from the round-robin rule
    logic stop;        // urgent case, ignore the rest of the scan
  } decision_t;

endpackage

// ----- src/msps_examine.sv -----
// Per-record decision logic: urgent cases, window check and round-robin.
module msps_examine #(
  parameter int IDX_W = 3
) (
  input  logic [msps_pkg::LIMIT_W-1:0] repeat_limit,
  input  logic                         path_active,
  input  logic                         challenge_verified,
  input  logic [msps_pkg::TIME_W-1:0]  challenge_time,
  input  logic [msps_pkg::TIME_W-1:0]  retransmit_timer,
  input  logic [msps_pkg::TIME_W-1:0]  time_now,
  input  logic [msps_pkg::REP_W-1:0]   challenge_repeats,
  input  logic                         response_pending,
  input  logic [msps_pkg::BYTES_W-1:0] congestion_window,
  input  logic [msps_pkg::BYTES_W-1:0] bytes_in_flight,
  input  logic                         action_needed,
  input  logic [IDX_W-1:0]             idx,
  input  logic                         pick_made,
  input  logic                         last_sent_valid,
  input  logic [IDX_W-1:0]             last_sent_idx,
  output msps_pkg::decision_t          decision
);
  import msps_pkg::*;

  logic [TIME_W-1:0] due_time;
  logic              challenge_due;
  logic              window_open;
  logic              is_last_sent;

  // Challenge deadline wraps at 64 bits
  assign due_time      = challenge_time + retransmit_timer;
  assign challenge_due = !challenge_verified && (due_time < time_now) &&
                         (challenge_repeats < repeat_limit);
  assign window_open   = congestion_window > bytes_in_flight;
  assign is_last_sent  = last_sent_valid && (last_sent_idx == idx);

  always_comb begin
    decision = '0;
    priority if (!path_active) begin
      decision = '0;
    end else if (challenge_due || response_pending) begin
      decision.take = 1'b1;
      decision.stop = 1'b1;
    end else if (!window_open) begin
      // provisional pick of the first verified path only
      decision.take = challenge_verified && !pick_made;
    end else if (action_needed) begin
      decision.take = 1'b1;
      decision.stop = 1'b1;
    end else if (challenge_verified) begin
      // round-robin: steer away from the last sent path; a first pick on the
      // last sent path stays provisional
      decision.take       = !pick_made || !is_last_sent;
      decision.take_valid = !is_last_sent;
    end else begin
      decision = '0;
    end
  end

endmodule

// ----- src/multipath_send_path_selector.sv -----
// Top level of the multipath send path selector.
//
// Usage: one scan sends one record word per proposed path on the in_ channel,
// in path index order, with in_tlast on the final record. Records past
// MAX_PATHS only count toward the end of the scan. After the last record a
// single result word appears on the out_ channel: the chosen path index, or
// default_used when no path qualified, plus an ACK reservation request.
// The chosen path becomes the last sent index and a reserved path is marked
// busy; busy marks persist until reset.
// Timing: a record is registered on acceptance and examined from the input
// register; the result word is registered when the last record leaves the
// input register.
// Throughput: one record per cycle, save a stalled last record; set by the
// single examine stage (64-bit add and compares) from input reg to scan state.
// Stall: while a result waits on out_tready, records that are not the last
// keep flowing; a last record waits in the input register.
// Reset: rst_n low clears scan state, busy marks, last sent index (none) and
// sets challenge_repeat_limit to 3. The cfg_ channel is always ready.
module multipath_send_path_selector #(
  parameter int MAX_PATHS = msps_pkg::DEFAULT_MAX_PATHS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: challenge_repeat_limit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msps_pkg::LIMIT_W-1:0]      cfg_data,
  // path records
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tlast,  // last_record
  // in_tdata, low bit up: path_active, challenge_verified, challenge_time,
  // retransmit_timer, time_now, challenge_repeats, response_pending,
  // congestion_window, bytes_in_flight, action_needed, stream_ready, zero fill
  input  logic [msps_pkg::IN_DATA_W-1:0]    in_tdata,
  // result
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, low bit up: path_chosen[2:0], default_used, reserve_ack,
  // zero fill
  output logic [msps_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import msps_pkg::*;

  localparam int IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int POS_W = $clog2(MAX_PATHS + 1);

  // Configuration register
  logic [LIMIT_W-1:0] limit_r;

  // Input register
  logic                 s1_valid_r;
  logic                 s1_last_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic                 s1_adv;

  // Scan state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] pick_idx_r, pick_idx_nxt;
  logic             pick_made_r, pick_made_nxt;
  logic             pick_valid_r, pick_valid_nxt;
  logic             stopped_r, stopped_nxt;

  // Persistent state
  logic                 ls_valid_r;
  logic [IDX_W-1:0]     ls_idx_r;
  logic [MAX_PATHS-1:0] ack_busy_r;

  // Result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                in_range;
  logic [IDX_W-1:0]    cur_idx;
  decision_t           dec;
  logic                res_load;
  logic                res_reserve;
  logic [7:0]          pick_wide;
  logic                stream_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // A last record may only leave the input register if the result slot is free
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_last_r <= in_tlast;
      s1_data_r <= in_tdata;
    end
  end

  assign in_range     = pos_r < POS_W'(MAX_PATHS);
  assign cur_idx      = pos_r[IDX_W-1:0];
  assign stream_ready = s1_data_r[OFS_STREAM];

  msps_examine #(
    .IDX_W (IDX_W)
  ) u_examine (
    .repeat_limit       (limit_r),
    .path_active        (s1_data_r[OFS_ACTIVE]),
    .challenge_verified (s1_data_r[OFS_VERIFIED]),
    .challenge_time     (s1_data_r[OFS_CH_TIME +: TIME_W]),
    .retransmit_timer   (s1_data_r[OFS_RTX +: TIME_W]),
    .time_now           (s1_data_r[OFS_NOW +: TIME_W]),
    .challenge_repeats  (s1_data_r[OFS_REPEATS +: REP_W]),
    .response_pending   (s1_data_r[OFS_RESP]),
    .congestion_window  (s1_data_r[OFS_CWND +: BYTES_W]),
    .bytes_in_flight    (s1_data_r[OFS_BIF +: BYTES_W]),
    .action_needed      (s1_data_r[OFS_ACTION]),
    .idx                (cur_idx),
    .pick_made          (pick_made_r),
    .last_sent_valid    (ls_valid_r),
    .last_sent_idx      (ls_idx_r),
    .decision           (dec)
  );

  // Running pick after this record
  always_comb begin
    pos_nxt        = pos_r;
    pick_idx_nxt   = pick_idx_r;
    pick_made_nxt  = pick_made_r;
    pick_valid_nxt = pick_valid_r;
    stopped_nxt    = stopped_r;
    if (in_range) begin
      pos_nxt = pos_r + POS_W'(1);
      if (!stopped_r) begin
        if (dec.take) begin
          pick_idx_nxt   = cur_idx;
          pick_made_nxt  = 1'b1;
          pick_valid_nxt = dec.take_valid;
        end
        if (dec.stop) begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  assign res_load    = s1_adv && s1_last_r;
  assign res_reserve = pick_made_nxt && pick_valid_nxt && stream_ready &&
                       !ack_busy_r[pick_idx_nxt];
  assign pick_wide   = 8'(pick_idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      pick_idx_r   <= '0;
      pick_made_r  <= 1'b0;
      pick_valid_r <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (res_load) begin
      // end of scan: back to a fresh scan
      pos_r        <= '0;
      pick_idx_r   <= '0;
      pick_made_r  <= 1'b0;
      pick_valid_r <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (s1_adv) begin
      pos_r        <= pos_nxt;
      pick_idx_r   <= pick_idx_nxt;
      pick_made_r  <= pick_made_nxt;
      pick_valid_r <= pick_valid_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // Last sent index and ACK busy marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_valid_r <= 1'b0;
      ls_idx_r   <= '0;
      ack_busy_r <= '0;
    end else if (res_load) begin
      ls_valid_r <= pick_made_nxt;
      ls_idx_r   <= pick_idx_nxt;
      if (res_reserve) begin
        ack_busy_r[pick_idx_nxt] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result word layout
  always_comb begin
    out_data_nxt = '0;
    if (pick_made_nxt) begin
      out_data_nxt[OUT_CHOSEN_W-1:0] = pick_wide[OUT_CHOSEN_W-1:0];
      out_data_nxt[OUT_CHOSEN_W+1]   = res_reserve;
    end else begin
      out_data_nxt[OUT_CHOSEN_W]     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The default path never carries an index or a reservation
  a_default_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_CHOSEN_W] |->
      (out_tdata[OUT_CHOSEN_W-1:0] == '0) && !out_tdata[OUT_CHOSEN_W+1])
    else $error("default result carries index or reservation");

  // A reservation leaves the chosen path marked busy
  a_busy_set: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res_reserve |=> ack_busy_r[$past(pick_idx_nxt)])
    else $error("reserved path not marked busy");

  // The position counter saturates at the path count
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_PATHS))
    else $error("scan position beyond path count");

  // Each result starts a fresh scan
  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (pos_r == '0) && !pick_made_r && !stopped_r && out_tvalid)
    else $error("scan state not cleared after result");

endmodule
